/* rtl/core/cpmi_pkg.sv */
// Shared types, constants and helper functions for the cubic minimum image core.
// No dependencies; imported by cpmi_axis and cubic_periodic_minimum_image_core.
package cpmi_pkg;

	// Coordinate format: signed Q16.16
	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int BOX_W     = 31;
	localparam int INV_W     = 32;
	localparam int SCALAR_W  = 64;
	// Scaled product carries FRAC_BITS + 31 fraction bits
	localparam int RND_SHIFT = FRAC_BITS + 31;
	// Sqrt pipeline: two result bits per stage
	localparam int SQRT_STAGES = 16;
	// Stages: six in each axis, one sum stage, then the root stages
	localparam int AXIS_STAGES = 6;
	localparam int LAST_STAGE  = AXIS_STAGES + 1 + SQRT_STAGES;

	localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(1) << FRAC_BITS;
	localparam logic [INV_W-1:0] INV_RESET = INV_W'(1) << 31;

	typedef enum logic [2:0] {
		ACT_IMAGE     = 3'd0,
		ACT_MINVEC    = 3'd1,
		ACT_DIST_SQ   = 3'd2,
		ACT_DIST      = 3'd3,
		ACT_FOLD      = 3'd4,
		ACT_FOLD_FRAC = 3'd5
	} act_t;

	// Register indexes on the configuration port
	localparam logic REG_BOX_LENGTH = 1'b0;
	localparam logic REG_INV_LENGTH = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] vec_x;
		logic signed [COORD_W-1:0] vec_y;
		logic signed [COORD_W-1:0] vec_z;
		logic [SCALAR_W-1:0]       scalar;
	} res_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] root;
	} sqrt_t;

	// Saturate a wide signed value to the coordinate range
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [51:0] v);
		logic signed [51:0] hi_lim;
		logic signed [51:0] lo_lim;
		hi_lim = 52'sd2147483647;
		lo_lim = -52'sd2147483648;
		if (v > hi_lim)
			return hi_lim[COORD_W-1:0];
		else if (v < lo_lim)
			return lo_lim[COORD_W-1:0];
		else
			return v[COORD_W-1:0];
	endfunction

	// One restoring step of the integer square root
	function automatic sqrt_t sqrt_step(input sqrt_t s, input int unsigned sh);
		logic [63:0] bv;
		logic [63:0] trial;
		sqrt_t o;
		bv    = 64'd1 << sh;
		trial = s.root + bv;
		if (s.rem >= trial) begin
			o.rem  = s.rem - trial;
			o.root = (s.root >> 1) + bv;
		end else begin
			o.rem  = s.rem;
			o.root = s.root >> 1;
		end
		return o;
	endfunction

endpackage

/* rtl/core/cpmi_axis.sv */
// One axis of the minimum image datapath: difference, cell count, wrap or fold,
// image add and square. Six register stages. Depends on cpmi_pkg.
module cpmi_axis import cpmi_pkg::*; (
	input  logic                       clk,
	input  logic                       en,
	input  logic [2:0]                 action,
	input  logic signed [COORD_W-1:0]  a,
	input  logic signed [COORD_W-1:0]  b,
	input  logic [BOX_W-1:0]           box_len,
	input  logic [INV_W-1:0]           inv_len,
	output logic signed [COORD_W-1:0]  vec_s6,
	output logic [62:0]                sq_s6
);

	logic [2:0]                act_s1, act_s2, act_s3, act_s4, act_s5;
	logic signed [32:0]        d_s1, d_s2, d_s3, d_s4;
	logic                      neg_s1, neg_s2, neg_s3, neg_s4;
	logic signed [COORD_W-1:0] b_s1, b_s2, b_s3, b_s4, b_s5;
	logic signed [33:0]        opnd_s1;
	logic [64:0]               prod_s2;
	logic [18:0]               n_s3;
	logic [46:0]               f_s3;
	logic [49:0]               p1_s4;
	logic [61:0]               p2_s4;
	logic [15:0]               fhi_s4;
	logic signed [COORD_W-1:0] w_s5;

	logic signed [32:0] d_c;
	logic [32:0]        m_c;
	logic               fold_c;
	logic signed [66:0] prod_c;
	logic [65:0]        rnd_c;
	logic [18:0]        x_c;
	logic signed [51:0] wr_c;
	logic [47:0]        fs_c;
	logic signed [COORD_W-1:0] w_c;
	logic signed [51:0] img_c;
	logic signed [63:0] sq_c;

	// Stage 1: difference and magnitude, or the point to fold
	always_comb begin
		if (action == ACT_IMAGE)
			d_c = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		else
			d_c = {b[COORD_W-1], b} - {a[COORD_W-1], a};
		m_c    = d_c[32] ? 33'(-d_c) : 33'(d_c);
		fold_c = action inside {ACT_FOLD, ACT_FOLD_FRAC};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1  <= action;
			d_s1    <= d_c;
			neg_s1  <= d_c[32];
			b_s1    <= b;
			// fold keeps the sign of the point; otherwise a non-negative magnitude
			opnd_s1 <= fold_c ? {a[COORD_W-1], a[COORD_W-1], a} : {1'b0, m_c};
		end
	end

	// Stage 2: scale by the reciprocal length (signed, so a fold wraps modulo)
	assign prod_c = opnd_s1 * $signed({1'b0, inv_len});

	always_ff @(posedge clk) begin
		if (en) begin
			act_s2  <= act_s1;
			d_s2    <= d_s1;
			neg_s2  <= neg_s1;
			b_s2    <= b_s1;
			prod_s2 <= prod_c[64:0];
		end
	end

	// Stage 3: round half away from zero to a cell count; keep the fraction
	assign rnd_c = {1'b0, prod_s2} + (66'd1 << (RND_SHIFT - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			act_s3 <= act_s2;
			d_s3   <= d_s2;
			neg_s3 <= neg_s2;
			b_s3   <= b_s2;
			n_s3   <= rnd_c[65:RND_SHIFT];
			f_s3   <= prod_s2[46:0];
		end
	end

	// Stage 4: multiply by the cell length (count, or fraction in two halves)
	assign x_c = (act_s3 inside {ACT_FOLD, ACT_FOLD_FRAC}) ? 19'(f_s3[46:31]) : n_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			act_s4 <= act_s3;
			d_s4   <= d_s3;
			neg_s4 <= neg_s3;
			b_s4   <= b_s3;
			p1_s4  <= 50'(x_c) * 50'(box_len);
			p2_s4  <= 62'(f_s3[30:0]) * 62'(box_len);
			fhi_s4 <= f_s3[46:31];
		end
	end

	// Stage 5: wrapped difference or folded coordinate
	always_comb begin
		if (neg_s4)
			wr_c = 52'(d_s4) + $signed({2'b00, p1_s4});
		else
			wr_c = 52'(d_s4) - $signed({2'b00, p1_s4});
		fs_c = p1_s4[47:0] + 48'(p2_s4[61:31]);
		case (act_s4)
			ACT_IMAGE, ACT_MINVEC, ACT_DIST_SQ, ACT_DIST: w_c = sat_coord(wr_c);
			ACT_FOLD:      w_c = fs_c[47:16];
			ACT_FOLD_FRAC: w_c = {16'd0, fhi_s4};
			default:       w_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s5 <= act_s4;
			b_s5   <= b_s4;
			w_s5   <= w_c;
		end
	end

	// Stage 6: add the reference point back, square the component
	assign img_c = 52'(b_s5) + 52'(w_s5);
	assign sq_c  = w_s5 * w_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s6 <= (act_s5 == ACT_IMAGE) ? sat_coord(img_c) : w_s5;
			sq_s6  <= sq_c[62:0];
		end
	end

endmodule

/* rtl/core/cubic_periodic_minimum_image_core.sv */
// Minimum image geometry in a periodic cubic cell, signed Q16.16 points.
// Depends on cpmi_pkg and cpmi_axis.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per pair of points
//   with an action code; output channel (out_valid/out_ready) returns exactly one
//   result transaction per input, in order.
//   Configuration: cfg_we writes cfg_wdata to register cfg_idx (0 cell length,
//   1 reciprocal length) at the clock edge; write only while the core is idle.
//   Pipeline: from input acceptance to out_valid a transaction passes six axis
//   stages, one sum stage and sixteen square-root stages (two root bits each),
//   the first loaded at the accepting edge, then the output register.
//   Throughput: one transaction per cycle while the skid buffer is empty.
//   Reset: arst_n clears all valid bits and the registers to length 1.0 and
//   reciprocal 1.0; the core is ready directly out of reset.
//   Stall: a one-entry skid buffer behind the output register takes the next
//   result; once it is full the whole pipeline holds and in_ready drops, with
//   nothing lost or repeated.
module cubic_periodic_minimum_image_core import cpmi_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_idx,
	input  logic [INV_W-1:0]           cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 action,
	input  logic signed [COORD_W-1:0]  first_x,
	input  logic signed [COORD_W-1:0]  first_y,
	input  logic signed [COORD_W-1:0]  first_z,
	input  logic signed [COORD_W-1:0]  second_x,
	input  logic signed [COORD_W-1:0]  second_y,
	input  logic signed [COORD_W-1:0]  second_z,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [COORD_W-1:0]  vec_x,
	output logic signed [COORD_W-1:0]  vec_y,
	output logic signed [COORD_W-1:0]  vec_z,
	output logic [SCALAR_W-1:0]        scalar
);

	logic [BOX_W-1:0] box_len_q;
	logic [INV_W-1:0] inv_len_q;
	logic             en;

	logic [LAST_STAGE:1]  vld_q;
	logic [2:0]           act_q   [1:LAST_STAGE];
	logic signed [COORD_W-1:0] vx_s6, vy_s6, vz_s6;
	logic [62:0]          sqx_s6, sqy_s6, sqz_s6;
	logic signed [COORD_W-1:0] vx_q [AXIS_STAGES+1:LAST_STAGE];
	logic signed [COORD_W-1:0] vy_q [AXIS_STAGES+1:LAST_STAGE];
	logic signed [COORD_W-1:0] vz_q [AXIS_STAGES+1:LAST_STAGE];
	logic [SCALAR_W-1:0]  sum_q [AXIS_STAGES+1:LAST_STAGE];
	sqrt_t                rt_in;
	sqrt_t                rt_c  [0:SQRT_STAGES-1];
	sqrt_t                rt_q  [1:SQRT_STAGES];

	res_t item_c;
	res_t out_q, skid_q;
	logic out_valid_q, skid_vld_q;
	logic arr, ld_out, ld_skid;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_len_q <= BOX_RESET;
			inv_len_q <= INV_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_BOX_LENGTH: box_len_q <= cfg_wdata[BOX_W-1:0];
				REG_INV_LENGTH: inv_len_q <= cfg_wdata;
				default:        inv_len_q <= inv_len_q;
			endcase
		end
	end

	// Pipeline advances unless the skid buffer is occupied
	assign en       = !skid_vld_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAST_STAGE-1:1], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_q[1] <= action;
			for (int k = 2; k <= LAST_STAGE; k++)
				act_q[k] <= act_q[k-1];
		end
	end

	// Per-axis datapath, stages 1 to 6
	cpmi_axis u_axis_x (
		.clk(clk), .en(en), .action(action), .a(first_x), .b(second_x),
		.box_len(box_len_q), .inv_len(inv_len_q), .vec_s6(vx_s6), .sq_s6(sqx_s6)
	);
	cpmi_axis u_axis_y (
		.clk(clk), .en(en), .action(action), .a(first_y), .b(second_y),
		.box_len(box_len_q), .inv_len(inv_len_q), .vec_s6(vy_s6), .sq_s6(sqy_s6)
	);
	cpmi_axis u_axis_z (
		.clk(clk), .en(en), .action(action), .a(first_z), .b(second_z),
		.box_len(box_len_q), .inv_len(inv_len_q), .vec_s6(vz_s6), .sq_s6(sqz_s6)
	);

	// Stage 7: squared distance (three squares of at most 2^62 cannot overflow)
	always_ff @(posedge clk) begin
		if (en) begin
			vx_q[AXIS_STAGES+1]  <= vx_s6;
			vy_q[AXIS_STAGES+1]  <= vy_s6;
			vz_q[AXIS_STAGES+1]  <= vz_s6;
			sum_q[AXIS_STAGES+1] <= 64'(sqx_s6) + 64'(sqy_s6) + 64'(sqz_s6);
			for (int k = AXIS_STAGES + 2; k <= LAST_STAGE; k++) begin
				vx_q[k]  <= vx_q[k-1];
				vy_q[k]  <= vy_q[k-1];
				vz_q[k]  <= vz_q[k-1];
				sum_q[k] <= sum_q[k-1];
			end
		end
	end

	// Square root stages, two result bits each
	assign rt_in = '{rem: sum_q[AXIS_STAGES+1], root: 64'd0};

	always_comb begin
		rt_c[0] = sqrt_step(sqrt_step(rt_in, 62), 60);
		for (int j = 1; j < SQRT_STAGES; j++)
			rt_c[j] = sqrt_step(sqrt_step(rt_q[j], 62 - 4*j), 60 - 4*j);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < SQRT_STAGES; j++)
				rt_q[j+1] <= rt_c[j];
		end
	end

	// Result assembly at the last stage
	always_comb begin
		item_c = '0;
		case (act_q[LAST_STAGE])
			ACT_IMAGE, ACT_MINVEC, ACT_FOLD, ACT_FOLD_FRAC: begin
				item_c.vec_x = vx_q[LAST_STAGE];
				item_c.vec_y = vy_q[LAST_STAGE];
				item_c.vec_z = vz_q[LAST_STAGE];
			end
			ACT_DIST_SQ: begin
				item_c.vec_x  = vx_q[LAST_STAGE];
				item_c.vec_y  = vy_q[LAST_STAGE];
				item_c.vec_z  = vz_q[LAST_STAGE];
				item_c.scalar = sum_q[LAST_STAGE];
			end
			ACT_DIST: begin
				item_c.vec_x  = vx_q[LAST_STAGE];
				item_c.vec_y  = vy_q[LAST_STAGE];
				item_c.vec_z  = vz_q[LAST_STAGE];
				item_c.scalar = rt_q[SQRT_STAGES].root;
			end
			default: item_c = '0;
		endcase
	end

	// Output register with skid buffer
	assign arr     = vld_q[LAST_STAGE] && en;
	assign ld_skid = out_valid_q && !out_ready && arr;
	assign ld_out  = !(out_valid_q && !out_ready) && (skid_vld_q || arr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_vld_q  <= 1'b0;
		end else begin
			if (ld_skid)
				skid_vld_q <= 1'b1;
			else if (!(out_valid_q && !out_ready))
				skid_vld_q <= 1'b0;
			if (!(out_valid_q && !out_ready))
				out_valid_q <= skid_vld_q || arr;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_skid)
			skid_q <= item_c;
		if (ld_out)
			out_q <= skid_vld_q ? skid_q : item_c;
	end

	assign out_valid = out_valid_q;
	assign vec_x     = out_q.vec_x;
	assign vec_y     = out_q.vec_y;
	assign vec_z     = out_q.vec_z;
	assign scalar    = out_q.scalar;

endmodule
